// ===== hw/rtl/kerning_pair_lookup_unit_macros.svh =====
// Assertion macros used by the kerning lookup port checker.
`ifndef KERNING_PAIR_LOOKUP_UNIT_MACROS_SVH
`define KERNING_PAIR_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define KPL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define KPL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/kpl_pkg.sv =====
// Shared types, codes and helpers of the kerning pair lookup unit.
`default_nettype none
package kpl_pkg;

   // Width of pair indexes, bucket starts and the pair count.
   localparam int CNT_W = 13;
   localparam int CHAR_W = 16;
   localparam int OFS_W = 16;
   localparam int TADDR_W = 12;

   // Request operation codes; code 3 is unused and dropped.
   typedef enum logic [1:0] {
      OP_WR_BUCKET = 2'd0,
      OP_WR_PAIR   = 2'd1,
      OP_LOOKUP    = 2'd2
   } kpl_op_type;

   // Pair table write from the request side.
   typedef struct packed {
      logic                     en;
      logic [TADDR_W-1:0]       addr;
      logic [CHAR_W-1:0]        key;
      logic signed [OFS_W-1:0]  offset;
   } kpl_pair_wr_type;

   // Scan command: clamped bucket bounds and the second character.
   typedef struct packed {
      logic              start;
      logic [CNT_W-1:0]  lo;
      logic [CNT_W-1:0]  hi;
      logic [CHAR_W-1:0] key;
   } kpl_scan_cmd_type;

   // Scan result, done pulses for one cycle.
   typedef struct packed {
      logic                     done;
      logic                     found;
      logic signed [OFS_W-1:0]  offset;
   } kpl_scan_rsp_type;

   // Limit a bucket bound to the pair count.
   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] limit);
      return (v > limit) ? limit : v;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/kpl_pair_scan.sv =====
// Pair table memory and the bucket scan engine, one entry per cycle.
`default_nettype none
module kpl_pair_scan #(
   parameter int MAX_PAIRS = 4096
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire kpl_pkg::kpl_pair_wr_type  pair_wr,
   input  wire kpl_pkg::kpl_scan_cmd_type scan_cmd,
   output      kpl_pkg::kpl_scan_rsp_type scan_rsp
);
   import kpl_pkg::*;

   localparam int PAIR_AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int EXT_W = 17;

   typedef enum logic [1:0] {
      SC_IDLE = 2'b01,
      SC_RUN  = 2'b10
   } scan_state_type;

   scan_state_type   state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CHAR_W-1:0] key_ff, key_in;
   logic             done_ff, done_in;
   logic             found_ff, found_in;
   logic signed [OFS_W-1:0] offset_ff, offset_in;

   // Pair memory: key in the upper half, offset in the lower half.
   logic [CHAR_W+OFS_W-1:0] pair_mem [MAX_PAIRS];
   logic [CHAR_W+OFS_W-1:0] rd_data_ff;
   logic                    rd_en;
   logic [CNT_W-1:0]        rd_idx;
   logic [EXT_W-1:0]        rd_ext;
   logic [EXT_W-1:0]        wr_ext;
   logic [CNT_W-1:0]        idx_next;
   logic [CHAR_W-1:0]       entry_key;

   assign rd_ext    = EXT_W'(rd_idx);
   assign wr_ext    = EXT_W'(pair_wr.addr);
   assign idx_next  = idx_ff + 1'b1;
   assign entry_key = rd_data_ff[CHAR_W+OFS_W-1:OFS_W];

   // Writes come only while no scan runs, so the two never meet on an entry.
   always_ff @(posedge clock) begin
      if (pair_wr.en) begin
         pair_mem[wr_ext[PAIR_AW-1:0]] <= {pair_wr.key, pair_wr.offset};
      end
      if (rd_en) begin
         rd_data_ff <= pair_mem[rd_ext[PAIR_AW-1:0]];
      end
   end

   // Scan sequencer: compare the entry read last cycle, prefetch the next.
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      hi_in     = hi_ff;
      key_in    = key_ff;
      done_in   = 1'b0;
      found_in  = found_ff;
      offset_in = offset_ff;
      rd_en     = 1'b0;
      rd_idx    = idx_next;
      unique case (state_ff)
         SC_IDLE: begin
            if (scan_cmd.start) begin
               hi_in  = scan_cmd.hi;
               key_in = scan_cmd.key;
               idx_in = scan_cmd.lo;
               if (scan_cmd.lo < scan_cmd.hi) begin
                  rd_en    = 1'b1;
                  rd_idx   = scan_cmd.lo;
                  state_in = SC_RUN;
               end else begin
                  done_in   = 1'b1;
                  found_in  = 1'b0;
                  offset_in = '0;
               end
            end
         end
         SC_RUN: begin
            priority if (entry_key == key_ff) begin
               done_in   = 1'b1;
               found_in  = 1'b1;
               offset_in = rd_data_ff[OFS_W-1:0];
               state_in  = SC_IDLE;
            end else if ((entry_key > key_ff) || (idx_next >= hi_ff)) begin
               done_in   = 1'b1;
               found_in  = 1'b0;
               offset_in = '0;
               state_in  = SC_IDLE;
            end else begin
               rd_en  = 1'b1;
               idx_in = idx_next;
            end
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      idx_ff    <= idx_in;
      hi_ff     <= hi_in;
      key_ff    <= key_in;
      found_ff  <= found_in;
      offset_ff <= offset_in;
   end

   assign scan_rsp.done   = done_ff;
   assign scan_rsp.found  = found_ff;
   assign scan_rsp.offset = offset_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/kerning_pair_lookup_unit.sv =====
// Kerning pair lookup unit top level: bucket table, scan control and result register.
// A write is done when it is accepted; a lookup with a character out of range goes straight
// to the result state, any other lookup reads the bucket bounds and scans the bucket first.
// Writes are taken back to back; after a lookup the next request is taken once its result
// is loaded, later while an untaken result blocks that load.
// Reset clears the control state and pair_count; both tables are undefined until written.
`default_nettype none
module kerning_pair_lookup_unit #(
   parameter int MAX_KERNED = 255,
   parameter int MAX_PAIRS  = 4096
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request channel.
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [1:0]                     req_opcode,
   input  wire logic [kpl_pkg::TADDR_W-1:0]    req_table_address,
   input  wire logic [kpl_pkg::CNT_W-1:0]      req_start_value,
   input  wire logic [kpl_pkg::CHAR_W-1:0]     req_entry_second_char,
   input  wire logic signed [kpl_pkg::OFS_W-1:0] req_entry_offset,
   input  wire logic [kpl_pkg::CHAR_W-1:0]     req_first_char,
   input  wire logic [kpl_pkg::CHAR_W-1:0]     req_second_char,
   // Result channel.
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic signed [kpl_pkg::OFS_W-1:0] rsp_kerning_offset,
   output      logic                           rsp_found,
   // Pair count register.
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [kpl_pkg::CNT_W-1:0]      csr_pair_count
);
   import kpl_pkg::*;

   localparam int BKT_AW = $clog2(MAX_KERNED + 1);
   localparam int EXT_W = 17;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_BKT_LO = 5'b00010,
      ST_BKT_HI = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  pair_count_ff;
   logic [BKT_AW-1:0] first_ff, first_in;
   logic [CHAR_W-1:0] second_ff, second_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic              pend_found_ff, pend_found_in;
   logic signed [OFS_W-1:0] pend_offset_ff, pend_offset_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   logic signed [OFS_W-1:0] rsp_offset_ff;
   logic              rsp_load;

   // Bucket start memory.
   logic [CNT_W-1:0]  bkt_mem [MAX_KERNED+1];
   logic [CNT_W-1:0]  bkt_rd_ff;
   logic              bkt_we;
   logic              bkt_re;
   logic [BKT_AW-1:0] bkt_raddr;

   logic [EXT_W-1:0]  taddr_ext;
   logic [EXT_W-1:0]  first_ext;
   logic [EXT_W-1:0]  second_ext;
   logic              chars_ok;
   logic              first_below_max;
   logic [CNT_W-1:0]  eff_count;
   logic [CNT_W-1:0]  hi_bound;
   logic              req_fire;

   kpl_pair_wr_type   pair_wr;
   kpl_scan_cmd_type  scan_cmd;
   kpl_scan_rsp_type  scan_rsp;

   assign taddr_ext  = EXT_W'(req_table_address);
   assign first_ext  = EXT_W'(req_first_char);
   assign second_ext = EXT_W'(req_second_char);
   assign chars_ok   = (first_ext != '0) && (first_ext <= EXT_W'(MAX_KERNED)) &&
                       (second_ext != '0) && (second_ext <= EXT_W'(MAX_KERNED));
   assign first_below_max = (EXT_W'(first_ff) < EXT_W'(MAX_KERNED));

   // Pair count limited to the table depth.
   assign eff_count = (EXT_W'(pair_count_ff) > EXT_W'(MAX_PAIRS)) ?
                      CNT_W'(MAX_PAIRS) : pair_count_ff;

   // Upper bound of the bucket: next start, or the count for the last character.
   assign hi_bound = first_below_max ? clamp_count(bkt_rd_ff, eff_count) : eff_count;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Bucket memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bkt_mem[taddr_ext[BKT_AW-1:0]] <= req_start_value;
      end
      if (bkt_re) begin
         bkt_rd_ff <= bkt_mem[bkt_raddr];
      end
   end

   // Pair table and scan engine.
   kpl_pair_scan #(
      .MAX_PAIRS (MAX_PAIRS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .pair_wr  (pair_wr),
      .scan_cmd (scan_cmd),
      .scan_rsp (scan_rsp)
   );

   // Request decode and lookup sequencer.
   always_comb begin
      state_in       = state_ff;
      first_in       = first_ff;
      second_in      = second_ff;
      lo_in          = lo_ff;
      pend_found_in  = pend_found_ff;
      pend_offset_in = pend_offset_ff;
      bkt_we         = 1'b0;
      bkt_re         = 1'b0;
      bkt_raddr      = first_ext[BKT_AW-1:0];
      rsp_load       = 1'b0;
      pair_wr.en     = 1'b0;
      pair_wr.addr   = req_table_address;
      pair_wr.key    = req_entry_second_char;
      pair_wr.offset = req_entry_offset;
      scan_cmd.start = 1'b0;
      scan_cmd.lo    = lo_ff;
      scan_cmd.hi    = hi_bound;
      scan_cmd.key   = second_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (kpl_op_type'(req_opcode))
                  OP_WR_BUCKET: begin
                     bkt_we = (taddr_ext <= EXT_W'(MAX_KERNED));
                  end
                  OP_WR_PAIR: begin
                     pair_wr.en = (taddr_ext < EXT_W'(MAX_PAIRS));
                  end
                  OP_LOOKUP: begin
                     first_in  = first_ext[BKT_AW-1:0];
                     second_in = req_second_char;
                     if (chars_ok) begin
                        bkt_re   = 1'b1;
                        state_in = ST_BKT_LO;
                     end else begin
                        pend_found_in  = 1'b0;
                        pend_offset_in = '0;
                        state_in       = ST_RESULT;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_BKT_LO: begin
            lo_in = clamp_count(bkt_rd_ff, eff_count);
            if (first_below_max) begin
               bkt_re    = 1'b1;
               bkt_raddr = BKT_AW'({1'b0, first_ff} + 1'b1);
            end
            state_in = ST_BKT_HI;
         end
         ST_BKT_HI: begin
            scan_cmd.start = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_rsp.done) begin
               pend_found_in  = scan_rsp.found;
               pend_offset_in = scan_rsp.offset;
               state_in       = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register: holds the beat until it is taken.
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         pair_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            pair_count_ff <= csr_pair_count;
         end
      end
      first_ff       <= first_in;
      second_ff      <= second_in;
      lo_ff          <= lo_in;
      pend_found_ff  <= pend_found_in;
      pend_offset_ff <= pend_offset_in;
      if (rsp_load) begin
         rsp_found_ff  <= pend_found_ff;
         rsp_offset_ff <= pend_offset_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_kerning_offset = rsp_offset_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/kpl_port_checker.sv =====
// Port-level assertions for the kerning lookup unit and their bind.
`default_nettype none
`include "kerning_pair_lookup_unit_macros.svh"
module kpl_port_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic [1:0]                       req_opcode,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic signed [kpl_pkg::OFS_W-1:0] rsp_kerning_offset,
   input wire logic                             rsp_found
);
   import kpl_pkg::*;

   logic req_fire;
   logic fire_write;
   logic fire_lookup;

   assign req_fire    = req_valid && req_ready;
   assign fire_write  = req_fire && ((req_opcode == OP_WR_BUCKET) || (req_opcode == OP_WR_PAIR));
   assign fire_lookup = req_fire && (req_opcode == OP_LOOKUP);

   // A stalled result beat keeps its payload.
   `KPL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_kerning_offset) && $stable(rsp_found),
      "result beat changed while stalled")

   // A miss always reports a zero offset.
   `KPL_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_found,
      rsp_kerning_offset == '0, "miss with nonzero offset")

   // After a table write the request side is ready again in the next cycle.
   `KPL_ASSERT_NEXT(a_write_one_cycle, clock, reset, fire_write, req_ready,
      "request side busy after a table write")

   // A lookup keeps the request side busy after it is taken.
   `KPL_ASSERT_NEXT(a_lookup_busy, clock, reset, fire_lookup, !req_ready,
      "request taken right after a lookup")

   // No result beat right after reset.
   `KPL_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid,
      "result beat right after reset")

endmodule

bind kerning_pair_lookup_unit kpl_port_checker u_kpl_port_checker (.*);
`default_nettype wire
